// ===== design/matrix_srt_decompose_top_macros.svh =====
// Assertion macros shared by the matrix decomposition RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef MATRIX_SRT_DECOMPOSE_TOP_MACROS_SVH
`define MATRIX_SRT_DECOMPOSE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msd_pkg.sv =====
// Shared types and constants for the matrix decomposition pipeline.
// No dependencies.
package msd_pkg;

    localparam int ENTRY_FRAC_BITS = 16;
    localparam int QUAT_FRAC_BITS  = 30;

    localparam longint SCALE_EPS_RAW = ((64'd1 << ENTRY_FRAC_BITS) + 500000) / 1000000;
    localparam longint QUAT_EPS_RAW  = ((64'd1 << QUAT_FRAC_BITS) + 500000) / 1000000;

    localparam logic [31:0] SCALE_EPS = (SCALE_EPS_RAW == 0) ? 32'd1 : 32'(SCALE_EPS_RAW);
    localparam logic [31:0] QUAT_EPS  = 32'(QUAT_EPS_RAW);
    localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] row0_col0;
        logic signed [31:0] row0_col1;
        logic signed [31:0] row0_col2;
        logic signed [31:0] row1_col0;
        logic signed [31:0] row1_col1;
        logic signed [31:0] row1_col2;
        logic signed [31:0] row2_col0;
        logic signed [31:0] row2_col1;
        logic signed [31:0] row2_col2;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_shift_x;
        logic signed [31:0] out_shift_y;
        logic signed [31:0] out_shift_z;
        logic [30:0]        scale_x;
        logic [30:0]        scale_y;
        logic [30:0]        scale_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
    } out_item_t;

endpackage

// ===== design/msd_sqrt.sv =====
// Pipelined floor square root, one root bit per register stage, several lanes.
// Uses no package; sideband bits travel alongside the lanes.
module msd_sqrt #(
    parameter int W     = 32,
    parameter int LANES = 1,
    parameter int PW    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][2*W-1:0]  rad,
    input  logic [PW-1:0]              side_in,
    output logic                       out_valid,
    output logic [LANES-1:0][W-1:0]    root,
    output logic [PW-1:0]              side_out
);
    logic                      vld_reg  [1:W];
    logic [LANES-1:0][W+1:0]   rem_reg  [1:W];
    logic [LANES-1:0][W-1:0]   rt_reg   [1:W];
    logic [LANES-1:0][2*W-1:0] rad_reg  [1:W];
    logic [PW-1:0]             side_reg [1:W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic                      cur_vld;
        logic [LANES-1:0][W+1:0]   cur_rem;
        logic [LANES-1:0][W-1:0]   cur_rt;
        logic [LANES-1:0][2*W-1:0] cur_rad;
        logic [PW-1:0]             cur_side;
        logic [LANES-1:0][W+1:0]   rem_next;
        logic [LANES-1:0][W-1:0]   rt_next;
        logic [LANES-1:0][2*W-1:0] rad_next;

        if (s == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_rem  = '0;
            assign cur_rt   = '0;
            assign cur_rad  = rad;
            assign cur_side = side_in;
        end
        else begin : g_rest
            assign cur_vld  = vld_reg[s];
            assign cur_rem  = rem_reg[s];
            assign cur_rt   = rt_reg[s];
            assign cur_rad  = rad_reg[s];
            assign cur_side = side_reg[s];
        end

        // one digit step: bring down two radicand bits, try root*4+1
        always_comb
        begin
            logic [W+3:0] trial;
            logic [W+3:0] cand;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {cur_rem[l], cur_rad[l][2*W-1 -: 2]};
                cand  = {2'b00, cur_rt[l], 2'b01};
                if (trial >= cand)
                begin
                    rem_next[l] = (W+2)'(trial - cand);
                    rt_next[l]  = {cur_rt[l][W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[W+1:0];
                    rt_next[l]  = {cur_rt[l][W-2:0], 1'b0};
                end
                rad_next[l] = {cur_rad[l][2*W-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= cur_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= rem_next;
                rt_reg[s+1]   <= rt_next;
                rad_reg[s+1]  <= rad_next;
                side_reg[s+1] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[W];
    assign root      = rt_reg[W];
    assign side_out  = side_reg[W];

endmodule

// ===== design/msd_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, several lanes.
// Uses no package; the numerator must be below den * 2^QW.
module msd_div #(
    parameter int DW    = 32,
    parameter int QW    = 31,
    parameter int LANES = 1,
    parameter int PW    = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [LANES-1:0][DW+QW-1:0]  num,
    input  logic [LANES-1:0][DW-1:0]     den,
    input  logic [PW-1:0]                side_in,
    output logic                         out_valid,
    output logic [LANES-1:0][QW-1:0]     quo,
    output logic [PW-1:0]                side_out
);
    logic                        vld_reg  [1:QW];
    logic [LANES-1:0][DW+QW-1:0] acc_reg  [1:QW];
    logic [LANES-1:0][DW-1:0]    den_reg  [1:QW];
    logic [PW-1:0]               side_reg [1:QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic                        cur_vld;
        logic [LANES-1:0][DW+QW-1:0] cur_acc;
        logic [LANES-1:0][DW-1:0]    cur_den;
        logic [PW-1:0]               cur_side;
        logic [LANES-1:0][DW+QW-1:0] acc_next;

        if (s == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_acc  = num;
            assign cur_den  = den;
            assign cur_side = side_in;
        end
        else begin : g_rest
            assign cur_vld  = vld_reg[s];
            assign cur_acc  = acc_reg[s];
            assign cur_den  = den_reg[s];
            assign cur_side = side_reg[s];
        end

        // partial remainder sits above the numerator bits, quotient shifts in below
        always_comb
        begin
            logic [DW:0] trial;
            logic [DW:0] diff;
            logic        take;
            for (int l = 0; l < LANES; l++)
            begin
                trial = cur_acc[l][DW+QW-1:QW-1];
                take  = trial >= {1'b0, cur_den[l]};
                diff  = take ? trial - {1'b0, cur_den[l]} : trial;
                acc_next[l] = {diff[DW-1:0], cur_acc[l][QW-2:0], take};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= cur_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s+1]  <= acc_next;
                den_reg[s+1]  <= cur_den;
                side_reg[s+1] <= cur_side;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quo[l] = acc_reg[QW][l][QW-1:0];
    end

    assign out_valid = vld_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// ===== design/matrix_srt_decompose_top.sv =====
// Affine matrix to translation, per-row scale and unit quaternion.
// One transform per cycle is accepted whenever the pipeline is not held.
// The pipeline holds three 32-stage square roots and three 31/32-stage dividers in series.
// The whole pipeline holds when the output register is full and not taken.
// Reset (rst_n low, asynchronous) clears all valid bits; payload is not reset.
`include "matrix_srt_decompose_top_macros.svh"

module matrix_srt_decompose_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  msd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output msd_pkg::out_item_t out_data
);
    import msd_pkg::*;

    typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} branch_t;

    typedef struct packed {
        logic [8:0][31:0] ent;
        logic [2:0][31:0] shift;
    } front_t;

    typedef struct packed {
        logic [2:0][31:0] shift;
        logic [2:0][30:0] scale;
    } pass_t;

    typedef struct packed {
        pass_t      pass;
        logic [8:0] neg;
    } d1side_t;

    typedef struct packed {
        pass_t            pass;
        branch_t          br;
        logic [2:0][33:0] numr;
    } s2side_t;

    typedef struct packed {
        pass_t       pass;
        branch_t     br;
        logic [2:0]  neg;
        logic [31:0] big;
    } d2side_t;

    typedef struct packed {
        pass_t            pass;
        logic [3:0][31:0] q;
    } s3side_t;

    typedef struct packed {
        pass_t            pass;
        logic             norm;
        logic [3:0]       neg;
        logic [3:0][31:0] q;
    } d3side_t;

    localparam logic signed [34:0] ONE_T = 35'(64'd1 << QUAT_FRAC_BITS);
    localparam logic signed [31:0] QONE  = 32'(64'd1 << QUAT_FRAC_BITS);

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [32:0] mag34(input logic [33:0] v);
        logic [33:0] n;
        n = v[33] ? 34'(-v) : v;
        return n[32:0];
    endfunction

    function automatic logic [33:0] sx34(input logic [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // input view
    front_t f_in;
    assign f_in.ent   = {in_data.row2_col2, in_data.row2_col1, in_data.row2_col0,
                         in_data.row1_col2, in_data.row1_col1, in_data.row1_col0,
                         in_data.row0_col2, in_data.row0_col1, in_data.row0_col0};
    assign f_in.shift = {in_data.shift_z, in_data.shift_y, in_data.shift_x};

    // stage 1: squares of entry magnitudes
    logic             v1_reg;
    front_t           f1_reg;
    logic [8:0][63:0] sq1_reg, sq1_next;

    always_comb
    begin
        logic [31:0] m;
        for (int i = 0; i < 9; i++)
        begin
            m = mag32(f_in.ent[i]);
            sq1_next[i] = m * m;
        end
    end

    // stage 2: row sums of squares
    logic             v2_reg;
    front_t           f2_reg;
    logic [2:0][63:0] ss2_reg, ss2_next;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            ss2_next[r] = sq1_reg[3*r] + sq1_reg[3*r+1] + sq1_reg[3*r+2];
    end

    // row lengths
    logic             v3w;
    logic [2:0][31:0] len3w;
    front_t           f3w;

    msd_sqrt #(.W(32), .LANES(3), .PW($bits(front_t))) u_row_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2_reg), .rad(ss2_reg), .side_in(f2_reg),
        .out_valid(v3w), .root(len3w), .side_out(f3w)
    );

    // stage 4: clamp, scale saturation, rounded division setup
    logic             v4_reg;
    logic [8:0][62:0] num4_reg, num4_next;
    logic [8:0][31:0] den4_reg, den4_next;
    d1side_t          d1s4_reg, d1s4_next;

    always_comb
    begin
        logic [31:0] lc;
        logic [31:0] m;
        d1s4_next.pass.shift = f3w.shift;
        for (int r = 0; r < 3; r++)
        begin
            lc = (len3w[r] < SCALE_EPS) ? SCALE_EPS : len3w[r];
            d1s4_next.pass.scale[r] = (lc > SAT_MAX) ? SAT_MAX[30:0] : lc[30:0];
            for (int c = 0; c < 3; c++)
            begin
                m = mag32(f3w.ent[3*r+c]);
                num4_next[3*r+c] = (63'(m) << QUAT_FRAC_BITS) + 63'(lc >> 1);
                den4_next[3*r+c] = lc;
                d1s4_next.neg[3*r+c] = f3w.ent[3*r+c][31];
            end
        end
    end

    // rotation entries
    logic             v5w;
    logic [8:0][30:0] q5w;
    d1side_t          d1s5w;

    msd_div #(.DW(32), .QW(31), .LANES(9), .PW($bits(d1side_t))) u_rot_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v4_reg), .num(num4_reg), .den(den4_reg), .side_in(d1s4_reg),
        .out_valid(v5w), .quo(q5w), .side_out(d1s5w)
    );

    // stage 5: signed rotation entries
    logic             v5_reg;
    logic [8:0][31:0] r5_reg, r5_next;
    pass_t            p5_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            r5_next[i] = d1s5w.neg[i] ? 32'(-{1'b0, q5w[i]}) : {1'b0, q5w[i]};
    end

    // stage 6: trace and branch choice
    logic             v6_reg;
    logic [8:0][31:0] r6_reg;
    branch_t          br6_reg, br6_next;
    pass_t            p6_reg;

    always_comb
    begin
        logic signed [33:0] tr;
        tr = $signed(sx34(r5_reg[0])) + $signed(sx34(r5_reg[4])) + $signed(sx34(r5_reg[8]));
        if (tr > 0)
            br6_next = BR_TRACE;
        else if ($signed(r5_reg[0]) > $signed(r5_reg[4]) &&
                 $signed(r5_reg[0]) > $signed(r5_reg[8]))
            br6_next = BR_X;
        else if ($signed(r5_reg[4]) > $signed(r5_reg[8]))
            br6_next = BR_Y;
        else
            br6_next = BR_Z;
    end

    // stage 7: branch radicand and off-diagonal numerators
    logic    v7_reg;
    logic [63:0] rad7_reg, rad7_next;
    s2side_t s2s7_reg, s2s7_next;

    always_comb
    begin
        logic signed [34:0] d0, d1, d2, t;
        logic signed [33:0] e01, e10, e02, e20, e12, e21;
        d0  = $signed({r6_reg[0][31], sx34(r6_reg[0])});
        d1  = $signed({r6_reg[4][31], sx34(r6_reg[4])});
        d2  = $signed({r6_reg[8][31], sx34(r6_reg[8])});
        e01 = $signed(sx34(r6_reg[1]));
        e02 = $signed(sx34(r6_reg[2]));
        e10 = $signed(sx34(r6_reg[3]));
        e12 = $signed(sx34(r6_reg[5]));
        e20 = $signed(sx34(r6_reg[6]));
        e21 = $signed(sx34(r6_reg[7]));
        s2s7_next.pass = p6_reg;
        s2s7_next.br   = br6_reg;
        case (br6_reg)
            BR_TRACE:
            begin
                t = ONE_T + d0 + d1 + d2;
                s2s7_next.numr[0] = e12 - e21;
                s2s7_next.numr[1] = e20 - e02;
                s2s7_next.numr[2] = e01 - e10;
            end
            BR_X:
            begin
                t = ONE_T + d0 - d1 - d2;
                s2s7_next.numr[0] = e12 - e21;
                s2s7_next.numr[1] = e01 + e10;
                s2s7_next.numr[2] = e20 + e02;
            end
            BR_Y:
            begin
                t = ONE_T + d1 - d0 - d2;
                s2s7_next.numr[0] = e20 - e02;
                s2s7_next.numr[1] = e01 + e10;
                s2s7_next.numr[2] = e12 + e21;
            end
            default:
            begin
                t = ONE_T + d2 - d0 - d1;
                s2s7_next.numr[0] = e01 - e10;
                s2s7_next.numr[1] = e20 + e02;
                s2s7_next.numr[2] = e12 + e21;
            end
        endcase
        if (t < 0)
            t = '0;
        rad7_next = 64'(t[33:0]) << QUAT_FRAC_BITS;
    end

    // branch root
    logic        v8w;
    logic [31:0] h8w;
    s2side_t     s2s8w;

    msd_sqrt #(.W(32), .LANES(1), .PW($bits(s2side_t))) u_br_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v7_reg), .rad(rad7_reg), .side_in(s2s7_reg),
        .out_valid(v8w), .root(h8w), .side_out(s2s8w)
    );

    // stage 8: divisor 2h and rounded numerators
    logic             v8_reg;
    logic [2:0][64:0] num8_reg, num8_next;
    logic [2:0][32:0] den8_reg, den8_next;
    d2side_t          d2s8_reg, d2s8_next;

    always_comb
    begin
        logic [32:0] d;
        logic [32:0] hp;
        d  = (h8w == '0) ? 33'd1 : {h8w, 1'b0};
        hp = {1'b0, h8w} + 33'd1;
        d2s8_next.pass = s2s8w.pass;
        d2s8_next.br   = s2s8w.br;
        d2s8_next.big  = hp[32:1];
        for (int k = 0; k < 3; k++)
        begin
            num8_next[k] = (65'(mag34(s2s8w.numr[k])) << QUAT_FRAC_BITS) + 65'(d >> 1);
            den8_next[k] = d;
            d2s8_next.neg[k] = s2s8w.numr[k][33];
        end
    end

    logic             v9w;
    logic [2:0][31:0] q9w;
    d2side_t          d2s9w;

    msd_div #(.DW(33), .QW(32), .LANES(3), .PW($bits(d2side_t))) u_quat_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v8_reg), .num(num8_reg), .den(den8_reg), .side_in(d2s8_reg),
        .out_valid(v9w), .quo(q9w), .side_out(d2s9w)
    );

    // stage 9: sign, saturate, place components (x, y, z, w)
    logic             v9_reg;
    logic [3:0][31:0] q9_reg, q9_next;
    pass_t            p9_reg;

    always_comb
    begin
        logic [2:0][31:0] v;
        logic [31:0]      s;
        for (int k = 0; k < 3; k++)
        begin
            s    = (q9w[k] > SAT_MAX) ? SAT_MAX : q9w[k];
            v[k] = d2s9w.neg[k] ? 32'(-s) : s;
        end
        case (d2s9w.br)
            BR_TRACE: q9_next = {d2s9w.big, v[2], v[1], v[0]};
            BR_X:     q9_next = {v[0], v[2], v[1], d2s9w.big};
            BR_Y:     q9_next = {v[0], v[2], d2s9w.big, v[1]};
            default:  q9_next = {v[0], d2s9w.big, v[2], v[1]};
        endcase
    end

    // stage 10: component squares
    logic             v10_reg;
    logic [3:0][61:0] sq10_reg, sq10_next;
    s3side_t          s3s10_reg;

    always_comb
    begin
        logic [31:0] m;
        for (int k = 0; k < 4; k++)
        begin
            m = mag32(q9_reg[k]);
            sq10_next[k] = m[30:0] * m[30:0];
        end
    end

    // stage 11: sum of squares
    logic        v11_reg;
    logic [63:0] ss11_reg, ss11_next;
    s3side_t     s3s11_reg;

    assign ss11_next = 64'(sq10_reg[0]) + 64'(sq10_reg[1]) + 64'(sq10_reg[2])
                     + 64'(sq10_reg[3]);

    logic        v12w;
    logic [31:0] len12w;
    s3side_t     s3s12w;

    msd_sqrt #(.W(32), .LANES(1), .PW($bits(s3side_t))) u_len_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v11_reg), .rad(ss11_reg), .side_in(s3s11_reg),
        .out_valid(v12w), .root(len12w), .side_out(s3s12w)
    );

    // stage 12: normalization setup
    logic             v12_reg;
    logic [3:0][62:0] num12_reg, num12_next;
    logic [3:0][31:0] den12_reg, den12_next;
    d3side_t          d3s12_reg, d3s12_next;

    always_comb
    begin
        logic norm;
        norm = len12w > QUAT_EPS;
        d3s12_next.pass = s3s12w.pass;
        d3s12_next.norm = norm;
        d3s12_next.q    = s3s12w.q;
        for (int k = 0; k < 4; k++)
        begin
            d3s12_next.neg[k] = s3s12w.q[k][31];
            num12_next[k] = norm ? (63'(mag32(s3s12w.q[k])) << QUAT_FRAC_BITS)
                                   + 63'(len12w >> 1) : '0;
            den12_next[k] = norm ? len12w : 32'd1;
        end
    end

    logic             v13w;
    logic [3:0][30:0] q13w;
    d3side_t          d3s13w;

    msd_div #(.DW(32), .QW(31), .LANES(4), .PW($bits(d3side_t))) u_norm_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v12_reg), .num(num12_reg), .den(den12_reg), .side_in(d3s12_reg),
        .out_valid(v13w), .quo(q13w), .side_out(d3s13w)
    );

    // output register
    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    always_comb
    begin
        logic [3:0][31:0] qf;
        for (int k = 0; k < 4; k++)
            qf[k] = !d3s13w.norm ? d3s13w.q[k] :
                    d3s13w.neg[k] ? 32'(-{1'b0, q13w[k]}) : {1'b0, q13w[k]};
        out_data_next.out_shift_x = d3s13w.pass.shift[0];
        out_data_next.out_shift_y = d3s13w.pass.shift[1];
        out_data_next.out_shift_z = d3s13w.pass.shift[2];
        out_data_next.scale_x     = d3s13w.pass.scale[0];
        out_data_next.scale_y     = d3s13w.pass.scale[1];
        out_data_next.scale_z     = d3s13w.pass.scale[2];
        out_data_next.quat_x      = qf[0];
        out_data_next.quat_y      = qf[1];
        out_data_next.quat_z      = qf[2];
        out_data_next.quat_w      = qf[3];
    end

    // valid bits of the glue stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v4_reg        <= v3w;
            v5_reg        <= v5w;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            v8_reg        <= v8w;
            v9_reg        <= v9w;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            v12_reg       <= v12w;
            out_valid_reg <= v13w;
        end
    end

    // payload of the glue stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg         <= f_in;
            sq1_reg        <= sq1_next;
            f2_reg         <= f1_reg;
            ss2_reg        <= ss2_next;
            num4_reg       <= num4_next;
            den4_reg       <= den4_next;
            d1s4_reg       <= d1s4_next;
            r5_reg         <= r5_next;
            p5_reg         <= d1s5w.pass;
            r6_reg         <= r5_reg;
            br6_reg        <= br6_next;
            p6_reg         <= p5_reg;
            rad7_reg       <= rad7_next;
            s2s7_reg       <= s2s7_next;
            num8_reg       <= num8_next;
            den8_reg       <= den8_next;
            d2s8_reg       <= d2s8_next;
            q9_reg         <= q9_next;
            p9_reg         <= d2s9w.pass;
            sq10_reg       <= sq10_next;
            s3s10_reg.q    <= q9_reg;
            s3s10_reg.pass <= p9_reg;
            ss11_reg       <= ss11_next;
            s3s11_reg      <= s3s10_reg;
            num12_reg      <= num12_next;
            den12_reg      <= den12_next;
            d3s12_reg      <= d3s12_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // the branch root is never small: the chosen diagonal keeps t near one or above
    `MSD_ASSERT_NOW(a_branch_root, v8w, h8w[31:29] != 3'b000, "branch root too small")

    // scales are clamped away from zero
    `MSD_ASSERT_NOW(a_scale_nonzero, out_valid,
        (out_data.scale_x != '0) && (out_data.scale_y != '0) && (out_data.scale_z != '0),
        "zero scale on output")

    // every quaternion component stays within one in magnitude
    `MSD_ASSERT_NOW(a_quat_range, out_valid,
        ($signed(out_data.quat_x) <= QONE) && ($signed(out_data.quat_x) >= -QONE) &&
        ($signed(out_data.quat_y) <= QONE) && ($signed(out_data.quat_y) >= -QONE) &&
        ($signed(out_data.quat_z) <= QONE) && ($signed(out_data.quat_z) >= -QONE) &&
        ($signed(out_data.quat_w) <= QONE) && ($signed(out_data.quat_w) >= -QONE),
        "quaternion component out of range")

    // a held result is not overwritten by the pipeline
    `MSD_ASSERT_NEXT(a_hold_output, out_valid && !out_ready,
        out_valid && (out_data == $past(out_data)), "stalled result changed")

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for matrix_srt_decompose_top: directed and random affine matrices.
// Depends on msd_pkg and the design sources; holds its own fixed-point predictor.
`timescale 1ns / 1ps

module testbench;
    import msd_pkg::*;

    localparam int     ONE_Q_SHIFT = QUAT_FRAC_BITS;
    localparam longint ONE_Q       = longint'(1) << QUAT_FRAC_BITS;
    localparam longint SAT_LIM     = 64'sd2147483647;
    localparam int     N_RANDOM    = 500;
    localparam int     LONG_HOLD   = 400;
    localparam int     DRAIN_CYC   = 260;

    // Random matrix flavors
    typedef enum int {MK_RAW, MK_SMALL, MK_SIGNPERM, MK_DIAG} mat_kind_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    bit hold_req;
    bit quiet;

    // Fixed-point helpers
    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // round to nearest, halves away from zero
    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned q;
        q = (mag(num) + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip_sym(longint v);
        if (v > SAT_LIM)
            return SAT_LIM;
        if (v < -SAT_LIM)
            return -SAT_LIM;
        return v;
    endfunction

    class decomp_scoreboard;
        out_item_t expected_q[$];
        int        mismatches;
        int        n_checked;
        int        branch_hits[4];
        int        sat_scales;

        function out_item_t decompose(in_item_t it);
            out_item_t        o;
            longint           m[3][3];
            longint           r[3][3];
            longint unsigned  ss, len, h, d, sumq, qlen;
            longint unsigned  lens[3];
            longint           tr, t, qx, qy, qz, qw;
            int               br;
            m[0][0] = it.row0_col0; m[0][1] = it.row0_col1; m[0][2] = it.row0_col2;
            m[1][0] = it.row1_col0; m[1][1] = it.row1_col1; m[1][2] = it.row1_col2;
            m[2][0] = it.row2_col0; m[2][1] = it.row2_col1; m[2][2] = it.row2_col2;
            // row lengths and normalized rotation
            for (int i = 0; i < 3; i++)
            begin
                ss = 0;
                for (int j = 0; j < 3; j++)
                    ss = ss + mag(m[i][j]) * mag(m[i][j]);
                len = floor_sqrt(ss);
                if (len < longint'(SCALE_EPS))
                    len = longint'(SCALE_EPS);
                lens[i] = (len > SAT_LIM) ? SAT_LIM : len;
                if (len > SAT_LIM)
                    sat_scales++;
                for (int j = 0; j < 3; j++)
                    r[i][j] = round_div(m[i][j] * ONE_Q, len);
            end
            // branch choice
            tr = r[0][0] + r[1][1] + r[2][2];
            if (tr > 0)
            begin
                br = 0;
                t = tr + ONE_Q;
            end
            else if (r[0][0] > r[1][1] && r[0][0] > r[2][2])
            begin
                br = 1;
                t = ONE_Q + r[0][0] - r[1][1] - r[2][2];
            end
            else if (r[1][1] > r[2][2])
            begin
                br = 2;
                t = ONE_Q + r[1][1] - r[0][0] - r[2][2];
            end
            else
            begin
                br = 3;
                t = ONE_Q + r[2][2] - r[0][0] - r[1][1];
            end
            branch_hits[br]++;
            if (t < 0)
                t = 0;
            h = floor_sqrt(longint'(t) << ONE_Q_SHIFT);
            d = 2 * h;
            if (d == 0)
                d = 1;
            case (br)
                0:
                begin
                    qw = longint'((h + 1) >> 1);
                    qx = round_div((r[1][2] - r[2][1]) * ONE_Q, d);
                    qy = round_div((r[2][0] - r[0][2]) * ONE_Q, d);
                    qz = round_div((r[0][1] - r[1][0]) * ONE_Q, d);
                end
                1:
                begin
                    qw = round_div((r[1][2] - r[2][1]) * ONE_Q, d);
                    qx = longint'((h + 1) >> 1);
                    qy = round_div((r[0][1] + r[1][0]) * ONE_Q, d);
                    qz = round_div((r[2][0] + r[0][2]) * ONE_Q, d);
                end
                2:
                begin
                    qw = round_div((r[2][0] - r[0][2]) * ONE_Q, d);
                    qx = round_div((r[0][1] + r[1][0]) * ONE_Q, d);
                    qy = longint'((h + 1) >> 1);
                    qz = round_div((r[1][2] + r[2][1]) * ONE_Q, d);
                end
                default:
                begin
                    qw = round_div((r[0][1] - r[1][0]) * ONE_Q, d);
                    qx = round_div((r[2][0] + r[0][2]) * ONE_Q, d);
                    qy = round_div((r[1][2] + r[2][1]) * ONE_Q, d);
                    qz = longint'((h + 1) >> 1);
                end
            endcase
            qx = clip_sym(qx);
            qy = clip_sym(qy);
            qz = clip_sym(qz);
            qw = clip_sym(qw);
            // normalize unless the length is tiny
            sumq = mag(qx) * mag(qx) + mag(qy) * mag(qy)
                 + mag(qz) * mag(qz) + mag(qw) * mag(qw);
            qlen = floor_sqrt(sumq);
            if (qlen > longint'(QUAT_EPS))
            begin
                qx = round_div(qx * ONE_Q, qlen);
                qy = round_div(qy * ONE_Q, qlen);
                qz = round_div(qz * ONE_Q, qlen);
                qw = round_div(qw * ONE_Q, qlen);
            end
            o.out_shift_x = it.shift_x;
            o.out_shift_y = it.shift_y;
            o.out_shift_z = it.shift_z;
            o.scale_x     = lens[0][30:0];
            o.scale_y     = lens[1][30:0];
            o.scale_z     = lens[2][30:0];
            o.quat_x      = qx[31:0];
            o.quat_y      = qy[31:0];
            o.quat_z      = qz[31:0];
            o.quat_w      = qw[31:0];
            return o;
        endfunction

        function void note_input(in_item_t it);
            expected_q = {expected_q, decompose(it)};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("[%0t] mismatch on %s: got %0h want %0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", 0, 0);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.out_shift_x !== want.out_shift_x)
                report_mismatch("out_shift_x", got.out_shift_x, want.out_shift_x);
            if (got.out_shift_y !== want.out_shift_y)
                report_mismatch("out_shift_y", got.out_shift_y, want.out_shift_y);
            if (got.out_shift_z !== want.out_shift_z)
                report_mismatch("out_shift_z", got.out_shift_z, want.out_shift_z);
            if (got.scale_x !== want.scale_x)
                report_mismatch("scale_x", got.scale_x, want.scale_x);
            if (got.scale_y !== want.scale_y)
                report_mismatch("scale_y", got.scale_y, want.scale_y);
            if (got.scale_z !== want.scale_z)
                report_mismatch("scale_z", got.scale_z, want.scale_z);
            if (got.quat_x !== want.quat_x)
                report_mismatch("quat_x", got.quat_x, want.quat_x);
            if (got.quat_y !== want.quat_y)
                report_mismatch("quat_y", got.quat_y, want.quat_y);
            if (got.quat_z !== want.quat_z)
                report_mismatch("quat_z", got.quat_z, want.quat_z);
            if (got.quat_w !== want.quat_w)
                report_mismatch("quat_w", got.quat_w, want.quat_w);
        endtask
    endclass

    decomp_scoreboard sb;

    matrix_srt_decompose_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Build a matrix from nine entries and a random translation
    function automatic in_item_t make_mat(longint a00, longint a01, longint a02,
                                          longint a10, longint a11, longint a12,
                                          longint a20, longint a21, longint a22);
        in_item_t it;
        it.row0_col0 = a00[31:0]; it.row0_col1 = a01[31:0]; it.row0_col2 = a02[31:0];
        it.row1_col0 = a10[31:0]; it.row1_col1 = a11[31:0]; it.row1_col2 = a12[31:0];
        it.row2_col0 = a20[31:0]; it.row2_col1 = a21[31:0]; it.row2_col2 = a22[31:0];
        it.shift_x   = $urandom;
        it.shift_y   = $urandom;
        it.shift_z   = $urandom;
        return it;
    endfunction

    function automatic longint small_val();
        return longint'($urandom_range(0, 262144)) - 131072;
    endfunction

    function automatic in_item_t random_mat();
        in_item_t  it;
        mat_kind_t kind;
        longint    e[9];
        int        p0, p1;
        longint    sc;
        kind = mat_kind_t'($urandom_range(0, 3));
        for (int k = 0; k < 9; k++)
            e[k] = 0;
        case (kind)
            MK_RAW:
                for (int k = 0; k < 9; k++)
                    e[k] = longint'(int'($urandom));
            MK_SMALL:
                for (int k = 0; k < 9; k++)
                    e[k] = small_val();
            MK_SIGNPERM:
            begin
                // scaled signed permutation plus a little noise
                p0 = $urandom_range(0, 2);
                p1 = (p0 + 1 + $urandom_range(0, 1)) % 3;
                sc = longint'($urandom_range(1, 1 << 20));
                e[p0]         = $urandom_range(0, 1) ? sc : -sc;
                e[3 + p1]     = $urandom_range(0, 1) ? sc : -sc;
                e[6 + 3 - p0 - p1] = $urandom_range(0, 1) ? sc : -sc;
                for (int k = 0; k < 9; k++)
                    e[k] = e[k] + longint'($urandom_range(0, 512)) - 256;
            end
            default:
            begin
                e[0] = small_val();
                e[4] = small_val();
                e[8] = small_val();
            end
        endcase
        it = make_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
        return it;
    endfunction

    // One input transfer; called at a falling edge
    task automatic push_item(input in_item_t it);
        in_valid = 1'b1;
        in_data  = it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it);
    endtask

    task automatic sender_gap(input int n);
        in_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Result side: random stalls and one long hold-off
    initial
    begin
        bit hold_done;
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Stimulus and end of run
    initial
    begin
        in_item_t dir_q[$];
        longint   mx;
        longint   mn;
        longint   one;
        int       drain;
        sb = new();
        mx  = 64'sd2147483647;
        mn  = -64'sd2147483648;
        one = 64'sd65536;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        hold_req = 1'b0;
        quiet    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // identity, zero, the four branches, extremes
        dir_q = {dir_q, make_mat(one, 0, 0, 0, one, 0, 0, 0, one)};
        dir_q = {dir_q, make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0)};
        dir_q = {dir_q, make_mat(one, 0, 0, 0, -one, 0, 0, 0, -one)};
        dir_q = {dir_q, make_mat(-one, 0, 0, 0, one, 0, 0, 0, -one)};
        dir_q = {dir_q, make_mat(-one, 0, 0, 0, -one, 0, 0, 0, one)};
        dir_q = {dir_q, make_mat(0, one, 0, -one, 0, 0, 0, 0, one)};
        dir_q = {dir_q, make_mat(mx, mx, mx, mx, mx, mx, mx, mx, mx)};
        dir_q = {dir_q, make_mat(mn, mn, mn, mn, mn, mn, mn, mn, mn)};
        dir_q = {dir_q, make_mat(mn, 0, 0, 0, mx, 0, 0, 0, mn)};
        dir_q = {dir_q, make_mat(mx, mn, 0, mn, mx, 0, 0, 0, mx)};
        dir_q = {dir_q, make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1)};
        dir_q = {dir_q, make_mat(-1, 0, 0, 0, -1, 0, 0, 0, -1)};
        dir_q = {dir_q, make_mat(0, 0, 1, 0, 0, 0, 0, 0, 0)};
        dir_q = {dir_q, make_mat(3 * one, 0, 0, 0, 5 * one, 0, 0, 0, 7 * one)};
        dir_q = {dir_q, make_mat(one, one, 0, one, one, 0, one, one, 0)};
        dir_q = {dir_q, make_mat(0, -one, 0, 0, 0, -one, -one, 0, 0)};
        dir_q = {dir_q, make_mat(mx, 0, 0, 0, 0, mn, 0, mx, 0)};
        foreach (dir_q[k])
        begin
            @(negedge clk);
            push_item(dir_q[k]);
        end
        // pass-through extremes
        @(negedge clk);
        begin
            in_item_t it;
            it = make_mat(one, 0, 0, 0, one, 0, 0, 0, one);
            it.shift_x = 32'h7FFF_FFFF;
            it.shift_y = 32'h8000_0000;
            it.shift_z = 32'hFFFF_FFFF;
            push_item(it);
        end

        // random part
        for (int i = 0; i < N_RANDOM; i++)
        begin
            @(negedge clk);
            if (i == N_RANDOM - 80)
                quiet = 1'b1;
            if (i == 150)
                hold_req = 1'b1;
            if (i == 320)
            begin
                // let the pipeline drain completely
                in_valid = 1'b0;
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            if (!quiet && $urandom_range(0, 5) == 0)
                sender_gap($urandom_range(1, 18));
            push_item(random_mat());
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        drain = DRAIN_CYC;
        repeat (drain) @(negedge clk);

        $display("Checked %0d transforms; branches trace/x/y/z hit %0d/%0d/%0d/%0d",
                 sb.n_checked, sb.branch_hits[0], sb.branch_hits[1],
                 sb.branch_hits[2], sb.branch_hits[3]);
        $display("Saturated row lengths: %0d; output hold-off and full drain exercised",
                 sb.sat_scales);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
